>>> design/acr_pkg.sv
`timescale 1ns / 1ps

package acr_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W         = $clog2(CACHE_ENTRIES);
  localparam int TREE_LVLS     = IDX_W;
  localparam int TREE_W        = 2 ** IDX_W;
  localparam int LVL_W         = $clog2(TREE_LVLS + 1);

  localparam int PROTO_W = 32;
  localparam int HW_W    = 48;
  localparam int AGE_W   = 32;
  localparam int SLOT_W  = 4;

  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_LEARN  = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [PROTO_W-1:0] proto_addr;
    logic [HW_W-1:0]    hw_addr;
  } item_t;

  // Lowest set bit of a per-entry flag vector.
  function automatic logic [IDX_W-1:0] first_set(input logic [CACHE_ENTRIES-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int k = CACHE_ENTRIES - 1; k >= 0; k--) begin
      if (v[k]) r = IDX_W'(k);
    end
    return r;
  endfunction

endpackage

>>> design/acr_front.sv
`timescale 1ns / 1ps

module acr_front import acr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [PROTO_W-1:0] in_proto_addr,
  input  logic [HW_W-1:0]    in_hw_addr_in,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;
  logic             pop;

  assign in_stall = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = slot_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{opcode: in_opcode, proto_addr: in_proto_addr,
                            hw_addr: in_hw_addr_in};
    end
  end

endmodule

>>> design/acr_engine.sv
`timescale 1ns / 1ps

module acr_engine import acr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_hit,
  output logic [HW_W-1:0]   out_hw_addr_out,
  output logic [SLOT_W-1:0] out_slot_used
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MATCH = 3'd1;
  localparam logic [2:0] ST_FIND  = 3'd2;
  localparam logic [2:0] ST_MIN   = 3'd3;
  localparam logic [2:0] ST_EVICT = 3'd4;

  logic [2:0]               state_r, state_nxt;
  item_t                    cur_r;
  logic [CACHE_ENTRIES-1:0] valid_r;
  logic [PROTO_W-1:0]       proto_r [CACHE_ENTRIES];
  logic [HW_W-1:0]          hw_r    [CACHE_ENTRIES];
  logic [AGE_W-1:0]         age_r   [CACHE_ENTRIES];
  logic [AGE_W-1:0]         stamp_r, stamp_nxt;

  logic [CACHE_ENTRIES-1:0] match_r;
  logic [CACHE_ENTRIES-1:0] free_r;
  logic [AGE_W-1:0]         tage_r [TREE_W];
  logic [IDX_W-1:0]         tidx_r [TREE_W];
  logic [AGE_W-1:0]         tage_nxt [TREE_W];
  logic [IDX_W-1:0]         tidx_nxt [TREE_W];
  logic [LVL_W-1:0]         lvl_r, lvl_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_hit_r;
  logic [HW_W-1:0]          out_hw_r;
  logic [SLOT_W-1:0]        out_slot_r;

  logic                     found;
  logic                     any_free;
  logic [IDX_W-1:0]         match_slot;
  logic [IDX_W-1:0]         free_slot;
  logic                     wr_age;
  logic                     wr_data;
  logic [IDX_W-1:0]         wr_slot;
  logic                     res_set;
  logic                     res_hit;
  logic [HW_W-1:0]          res_hw;

  assign found      = |match_r;
  assign any_free   = |free_r;
  assign match_slot = first_set(match_r);
  assign free_slot  = first_set(free_r);
  assign stamp_nxt  = stamp_r + 1'b1;

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_hw_addr_out = out_hw_r;
  assign out_slot_used   = out_slot_r;

  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    q_pop     = 1'b0;
    wr_age    = 1'b0;
    wr_data   = 1'b0;
    wr_slot   = match_slot;
    res_set   = 1'b0;
    res_hit   = 1'b0;
    res_hw    = '0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_pop     = 1'b1;
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        state_nxt = ST_FIND;
      end
      ST_FIND: begin
        if (cur_r.opcode == OP_LOOKUP) begin
          res_set   = 1'b1;
          state_nxt = ST_IDLE;
          if (found) begin
            wr_age  = 1'b1;
            res_hit = 1'b1;
            res_hw  = hw_r[match_slot];
          end
        end else if (found) begin
          wr_age    = 1'b1;
          wr_data   = 1'b1;
          res_set   = 1'b1;
          res_hit   = 1'b1;
          state_nxt = ST_IDLE;
        end else if (any_free) begin
          wr_age    = 1'b1;
          wr_data   = 1'b1;
          wr_slot   = free_slot;
          res_set   = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          lvl_nxt   = '0;
          state_nxt = ST_MIN;
        end
      end
      ST_MIN: begin
        lvl_nxt = lvl_r + 1'b1;
        if (lvl_r == LVL_W'(TREE_LVLS - 1)) state_nxt = ST_EVICT;
      end
      ST_EVICT: begin
        wr_age    = 1'b1;
        wr_data   = 1'b1;
        wr_slot   = tidx_r[0];
        res_set   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // One tree level per cycle; on equal ages keep the lower index.
  always_comb begin
    for (int j = 0; j < TREE_W; j++) begin
      tage_nxt[j] = tage_r[j];
      tidx_nxt[j] = tidx_r[j];
    end
    for (int j = 0; j < TREE_W / 2; j++) begin
      if (tage_r[2*j+1] < tage_r[2*j]) begin
        tage_nxt[j] = tage_r[2*j+1];
        tidx_nxt[j] = tidx_r[2*j+1];
      end else begin
        tage_nxt[j] = tage_r[2*j];
        tidx_nxt[j] = tidx_r[2*j];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_set) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lvl_r       <= '0;
      stamp_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < CACHE_ENTRIES; k++) age_r[k] <= '0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_age) begin
        stamp_r        <= stamp_nxt;
        age_r[wr_slot] <= stamp_nxt;
      end
      if (wr_data) valid_r[wr_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_item;
    if (wr_data) begin
      proto_r[wr_slot] <= cur_r.proto_addr;
      hw_r[wr_slot]    <= cur_r.hw_addr;
    end
    if (state_r == ST_MATCH) begin
      for (int k = 0; k < CACHE_ENTRIES; k++) begin
        match_r[k] <= valid_r[k] && (proto_r[k] == cur_r.proto_addr);
        free_r[k]  <= !valid_r[k];
      end
      // Pad entries carry the largest age so a real entry always wins.
      for (int k = 0; k < TREE_W; k++) begin
        tage_r[k] <= (k < CACHE_ENTRIES) ? age_r[k % CACHE_ENTRIES] : '1;
        tidx_r[k] <= IDX_W'(k);
      end
    end else if (state_r == ST_MIN) begin
      for (int k = 0; k < TREE_W; k++) begin
        tage_r[k] <= tage_nxt[k];
        tidx_r[k] <= tidx_nxt[k];
      end
    end
    if (res_set) begin
      out_hit_r  <= res_hit;
      out_hw_r   <= res_hw;
      out_slot_r <= (cur_r.opcode == OP_LOOKUP && !found) ? '0 : SLOT_W'(wr_slot);
    end
  end

endmodule

>>> design/address_cache_lru.sv
`timescale 1ns / 1ps

// Fully associative cache from 32-bit protocol addresses to 48-bit hardware
// addresses with least-recently-used replacement over CACHE_ENTRIES slots.
// Each item yields exactly one result, in order. A two-entry input queue
// takes items while the lookup engine works, so in_stall rises only when
// the queue is full. The engine handles one item at a time: a lookup, or a
// learn that hits or finds a free slot, goes from the queue to out_valid
// through compare, resolve and result register; a learn that must evict
// runs the age minimum through a registered tree, one level per cycle,
// before the evicting write and the result register. The next item starts
// once the previous result has been taken. A lookup miss returns zeros and
// leaves the ages untouched.
module address_cache_lru import acr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [PROTO_W-1:0] in_proto_addr,
  input  logic [HW_W-1:0]    in_hw_addr_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [HW_W-1:0]    out_hw_addr_out,
  output logic [SLOT_W-1:0]  out_slot_used
);

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  acr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_proto_addr (in_proto_addr),
    .in_hw_addr_in (in_hw_addr_in),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  acr_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_hw_addr_out (out_hw_addr_out),
    .out_slot_used   (out_slot_used)
  );

endmodule

>>> design/acr_checker.sv
`timescale 1ns / 1ps

module acr_checker import acr_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_opcode,
  input logic [PROTO_W-1:0] in_proto_addr,
  input logic [HW_W-1:0]    in_hw_addr_in,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_hit,
  input logic [HW_W-1:0]    out_hw_addr_out,
  input logic [SLOT_W-1:0]  out_slot_used
);

  // Hold a stalled input transfer.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_opcode)
      && $stable(in_proto_addr) && $stable(in_hw_addr_in))
    else $error("stalled input changed");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit)
      && $stable(out_hw_addr_out) && $stable(out_slot_used))
    else $error("stalled result changed");

  // Only a lookup hit carries a hardware address.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hw_addr_out == '0)
    else $error("hardware address on a miss");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // No result can appear in the cycle right after reset releases.
  a_no_early: assert property (@(posedge clk)
    !rst_n ##1 rst_n |=> !out_valid)
    else $error("result too soon after reset");

endmodule

bind address_cache_lru acr_checker u_acr_checker (.*);

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import acr_pkg::*;

  typedef struct packed {
    logic              hit;
    logic [HW_W-1:0]   hw_addr;
    logic [SLOT_W-1:0] slot;
  } lookup_result_t;

  localparam int RANDOM_ITEMS   = 1650;
  localparam int POOL_SIZE      = 28;
  localparam int HOLD_AT_RESULT = 300;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_opcode = OP_LOOKUP;
  logic [PROTO_W-1:0] in_proto_addr = '0;
  logic [HW_W-1:0]    in_hw_addr_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_hit;
  logic [HW_W-1:0]    out_hw_addr_out;
  logic [SLOT_W-1:0]  out_slot_used;

  // Shadow copy of the cache contents.
  logic               cache_valid [CACHE_ENTRIES];
  logic [PROTO_W-1:0] cache_proto [CACHE_ENTRIES];
  logic [HW_W-1:0]    cache_hw    [CACHE_ENTRIES];
  logic [AGE_W-1:0]   cache_age   [CACHE_ENTRIES];
  logic [AGE_W-1:0]   stamp_ctr;

  item_t          request_q[$];
  lookup_result_t expected_result_q[$];
  item_t          sent_req;
  item_t          next_req;
  lookup_result_t got_result;
  lookup_result_t want_result;

  int n_requests = 0;
  int sent_cnt = 0;
  int recv_cnt = 0;
  int error_cnt = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int tx_idle_pct;
  int rx_idle_pct;

  address_cache_lru u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_proto_addr   (in_proto_addr),
    .in_hw_addr_in   (in_hw_addr_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_hw_addr_out (out_hw_addr_out),
    .out_slot_used   (out_slot_used)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int k = 0; k < CACHE_ENTRIES; k++) begin
      cache_valid[k] = 1'b0;
      cache_proto[k] = '0;
      cache_hw[k]    = '0;
      cache_age[k]   = '0;
    end
    stamp_ctr = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Apply one request to the shadow cache and return the result it yields.
  function automatic lookup_result_t resolve_address(input item_t req);
    int             match;
    int             slot;
    lookup_result_t res;
    match = -1;
    res   = '0;
    for (int k = 0; k < CACHE_ENTRIES; k++) begin
      if (match < 0 && cache_valid[k] && cache_proto[k] == req.proto_addr) match = k;
    end
    if (req.opcode == OP_LOOKUP) begin
      if (match >= 0) begin
        stamp_ctr        = stamp_ctr + 1'b1;
        cache_age[match] = stamp_ctr;
        res.hit          = 1'b1;
        res.hw_addr      = cache_hw[match];
        res.slot         = SLOT_W'(match);
      end
      return res;
    end
    slot = match;
    if (slot < 0) begin
      // lowest free slot first, otherwise the oldest stamp (lowest index on a tie)
      for (int k = CACHE_ENTRIES - 1; k >= 0; k--) begin
        if (!cache_valid[k]) slot = k;
      end
      if (slot < 0) begin
        slot = 0;
        for (int k = 1; k < CACHE_ENTRIES; k++) begin
          if (cache_age[k] < cache_age[slot]) slot = k;
        end
      end
    end
    stamp_ctr         = stamp_ctr + 1'b1;
    cache_proto[slot] = req.proto_addr;
    cache_hw[slot]    = req.hw_addr;
    cache_valid[slot] = 1'b1;
    cache_age[slot]   = stamp_ctr;
    res.hit           = (match >= 0);
    res.slot          = SLOT_W'(slot);
    return res;
  endfunction

  task automatic queue_request(input logic op, input logic [PROTO_W-1:0] addr,
                               input logic [HW_W-1:0] hw);
    item_t req;
    req.opcode     = op;
    req.proto_addr = addr;
    req.hw_addr    = hw;
    request_q.push_back(req);
  endtask

  // Sender: one transfer per accepted request, payload held while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sent_req.opcode     = in_opcode;
        sent_req.proto_addr = in_proto_addr;
        sent_req.hw_addr    = in_hw_addr_in;
        expected_result_q.push_back(resolve_address(sent_req));
        sent_cnt++;
      end
      tx_idle_pct = (sent_cnt < n_requests / 3) ? 28 :
                    (sent_cnt < 2 * n_requests / 3) ? 62 : 0;
      if (in_valid && in_stall) begin
        // hold the stalled transfer
      end else if (request_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        next_req = request_q.pop_front();
        in_valid      <= 1'b1;
        in_opcode     <= next_req.opcode;
        in_proto_addr <= next_req.proto_addr;
        in_hw_addr_in <= next_req.hw_addr;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_result.hit     = out_hit;
        got_result.hw_addr = out_hw_addr_out;
        got_result.slot    = out_slot_used;
        if (expected_result_q.size() == 0) begin
          $display("%0t: result with nothing expected: hit %0d hw %h slot %0d",
                   $time, out_hit, out_hw_addr_out, out_slot_used);
          error_cnt++;
        end else begin
          want_result = expected_result_q.pop_front();
          if (got_result.hit !== want_result.hit) begin
            $display("%0t: hit expected %0d got %0d", $time, want_result.hit, got_result.hit);
            error_cnt++;
          end
          if (got_result.hw_addr !== want_result.hw_addr) begin
            $display("%0t: hw_addr_out expected %h got %h",
                     $time, want_result.hw_addr, got_result.hw_addr);
            error_cnt++;
          end
          if (got_result.slot !== want_result.slot) begin
            $display("%0t: slot_used expected %0d got %0d",
                     $time, want_result.slot, got_result.slot);
            error_cnt++;
          end
        end
        recv_cnt++;
        // long hold-off so the input queue fills and stalls the sender
        if (recv_cnt == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
      end
      rx_idle_pct = (recv_cnt < n_requests / 3) ? 62 :
                    (recv_cnt < 2 * n_requests / 3) ? 28 : 0;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Abort if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("address_cache_lru test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [PROTO_W-1:0] addr_pool [POOL_SIZE];
    logic [PROTO_W-1:0] addr;
    logic [HW_W-1:0]    hw;
    logic               op;

    // Directed: empty miss, extremes, update, fill in slot order, then LRU evictions.
    queue_request(OP_LOOKUP, 32'h0000_0000, '1);
    queue_request(OP_LEARN,  32'hFFFF_FFFF, '1);
    queue_request(OP_LEARN,  32'h0000_0000, '0);
    queue_request(OP_LOOKUP, 32'hFFFF_FFFF, '0);
    queue_request(OP_LOOKUP, 32'h0000_0000, '1);
    queue_request(OP_LEARN,  32'hFFFF_FFFF, 48'h5555_AAAA_5555);
    for (int k = 0; k < CACHE_ENTRIES - 2; k++) begin
      queue_request(OP_LEARN, 32'hA5A5_0000 + k, {16'h0F0F, 32'(k)});
    end
    queue_request(OP_LOOKUP, 32'h0000_0000, '0);
    queue_request(OP_LEARN,  32'h1234_5678, 48'hAAAA_5555_AAAA);
    queue_request(OP_LEARN,  32'h8000_0001, 48'h8000_0000_0001);
    queue_request(OP_LOOKUP, 32'hFFFF_FFFF, '0);

    // Random: mostly a small working set so hits, updates and evictions are common.
    for (int k = 0; k < POOL_SIZE; k++) addr_pool[k] = $urandom;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(99) < 3) addr_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
      op   = ($urandom_range(99) < 45) ? OP_LEARN : OP_LOOKUP;
      addr = ($urandom_range(99) < 80) ? addr_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
      hw   = {16'($urandom_range(16'hFFFF)), 32'($urandom)};
      queue_request(op, addr, hw);
    end
    n_requests = request_q.size();

    @(posedge rst_n);
    while (request_q.size() != 0 || in_valid || expected_result_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_cnt == 0) begin
      $display("address_cache_lru test passed");
    end else begin
      $display("address_cache_lru test failed");
    end
    $finish;
  end

endmodule
